// File: rtl/core/line_pair_closest_approach_assert.svh
// Assertion macros used by the port-level checker of the closest-approach block.
`ifndef LINE_PAIR_CLOSEST_APPROACH_ASSERT_SVH
`define LINE_PAIR_CLOSEST_APPROACH_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define LPCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define LPCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Like LPCA_ASSERT_NEXT, but also checked while reset is applied.
`define LPCA_ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lpca_pkg.sv
// Types, widths and constants of the closest-approach block.
package lpca_pkg;

    localparam int COORD_W  = 32;
    localparam int DIFF_W   = 33;
    localparam int PROD_W   = 66;
    localparam int DOTS_W   = 68;
    localparam int DOT_SH   = 16;
    localparam int DOT_W    = DOTS_W - DOT_SH;
    localparam int MUL_W    = 2 * DOT_W;
    localparam int SPLIT_W  = 32;
    localparam int PHI_W    = DOT_W - SPLIT_W;
    localparam int WIDE_W   = 106;
    localparam int QUO_W    = 63;
    localparam int QFRAC_W  = 32;
    localparam int SAT_SH   = QUO_W - QFRAC_W;
    localparam int REM_W    = WIDE_W + QUO_W + 1;
    localparam int DIV_LAT  = QUO_W;
    localparam int SCAL_W   = 64;
    localparam int HALF_W   = 32;
    localparam int PPH_W    = HALF_W + COORD_W;
    localparam int PPL_W    = HALF_W + 1 + COORD_W;
    localparam int COMP_W   = 98;
    localparam int DIST_W   = 33;
    localparam int SQ_W     = 2 * DIST_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = 35;
    localparam int SQRT_LAT = ROOT_W;
    localparam int TRIAL_W  = 2 * ROOT_W + 2;
    localparam int THR_W    = 40;
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 64;
    localparam int ADDR_LSB = 3;
    localparam int REG_IDX_W = PADDR_W - ADDR_LSB;

    // Stages ahead of the divider, and after it up to the square root.
    localparam int PRE_DIV  = 8;
    localparam int POST_DIV = 6;
    localparam int PIPE_LEN = PRE_DIV + DIV_LAT + POST_DIV + SQRT_LAT;

    localparam logic [REG_IDX_W-1:0] REG_THR   = 1'b0;
    localparam logic [THR_W-1:0]     THR_RESET = 40'd4295;
    localparam logic [DIST_W-1:0]    DIST_MAX  = {DIST_W{1'b1}};

    typedef logic [2:0][COORD_W-1:0] vec3_t;
    typedef logic [2:0][DIFF_W-1:0]  wvec3_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_pos_x;
        logic signed [COORD_W-1:0] first_pos_y;
        logic signed [COORD_W-1:0] first_pos_z;
        logic signed [COORD_W-1:0] first_dir_x;
        logic signed [COORD_W-1:0] first_dir_y;
        logic signed [COORD_W-1:0] first_dir_z;
        logic signed [COORD_W-1:0] second_pos_x;
        logic signed [COORD_W-1:0] second_pos_y;
        logic signed [COORD_W-1:0] second_pos_z;
        logic signed [COORD_W-1:0] second_dir_x;
        logic signed [COORD_W-1:0] second_dir_y;
        logic signed [COORD_W-1:0] second_dir_z;
    } in_t;

    typedef struct packed {
        logic [DIST_W-1:0] closest_distance;
        logic              parallel_flag;
    } out_t;

    // Partial products of a wide signed multiply split at bit SPLIT_W.
    typedef struct packed {
        logic signed [2*PHI_W-1:0]     hh;
        logic signed [PHI_W+SPLIT_W:0] hl;
        logic signed [PHI_W+SPLIT_W:0] lh;
        logic        [2*SPLIT_W-1:0]   ll;
    } pprod_t;

    // Data that rides alongside the two dividers.
    typedef struct packed {
        vec3_t  u;
        vec3_t  v;
        wvec3_t w;
        logic   par;
        logic   sign_s;
        logic   sign_t;
        logic   zero_s;
        logic   zero_t;
        logic   sat_s;
        logic   sat_t;
    } div_side_t;

endpackage

// File: rtl/core/lpca_div.sv
// Pipelined restoring divider: one quotient bit per stage, quotient of num * 2^32 / den.
module lpca_div
    import lpca_pkg::*;
(
    input  logic              aclk,
    input  logic              ce,
    input  logic [WIDE_W-1:0] num_i,
    input  logic [WIDE_W-1:0] den_i,
    output logic [QUO_W-1:0]  quo_o
);

    logic [REM_W-1:0]  rem_reg [QUO_W-1];
    logic [WIDE_W-1:0] den_reg [QUO_W-1];
    logic [QUO_W-1:0]  q_reg   [QUO_W];

    for (genvar j = 0; j < QUO_W; j++) begin : g_step
        localparam int K = QUO_W - 1 - j;
        logic [REM_W-1:0]  rem_in;
        logic [REM_W-1:0]  trial;
        logic [WIDE_W-1:0] den_in;
        logic [QUO_W-1:0]  q_in;
        logic              ge;

        if (j == 0) begin : g_first
            assign rem_in = {{(REM_W-WIDE_W-QFRAC_W){1'b0}}, num_i, {QFRAC_W{1'b0}}};
            assign den_in = den_i;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        assign trial = {{(REM_W-WIDE_W){1'b0}}, den_in} << K;
        assign ge    = (rem_in >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                q_reg[j] <= {q_in[QUO_W-2:0], ge};
            end
        end

        if (j < QUO_W - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[j] <= ge ? rem_in - trial : rem_in;
                    den_reg[j] <= den_in;
                end
            end
        end
    end

    assign quo_o = q_reg[QUO_W-1];

endmodule

// File: rtl/core/lpca_sqrt.sv
// Pipelined integer square root: one root bit per stage, floor of the root.
module lpca_sqrt
    import lpca_pkg::*;
(
    input  logic              aclk,
    input  logic              ce,
    input  logic [SUM_W-1:0]  sum_i,
    output logic [ROOT_W-1:0] root_o
);

    logic [SUM_W-1:0]  rem_reg [ROOT_W-1];
    logic [ROOT_W-1:0] res_reg [ROOT_W];

    for (genvar j = 0; j < ROOT_W; j++) begin : g_step
        localparam int K = ROOT_W - 1 - j;
        logic [SUM_W-1:0]   rem_in;
        logic [ROOT_W-1:0]  res_in;
        logic [TRIAL_W-1:0] trial;
        logic               ge;

        if (j == 0) begin : g_first
            assign rem_in = sum_i;
            assign res_in = '0;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign res_in = res_reg[j-1];
        end

        // (res + 2^K)^2 - res^2 = res * 2^(K+1) + 2^(2K)
        assign trial = ({{(TRIAL_W-ROOT_W){1'b0}}, res_in} << (K + 1))
                     + ({{(TRIAL_W-1){1'b0}}, 1'b1} << (2 * K));
        assign ge    = ({{(TRIAL_W-SUM_W){1'b0}}, rem_in} >= trial);

        always_ff @(posedge aclk) begin
            if (ce) begin
                res_reg[j] <= ge ? (res_in | ({{(ROOT_W-1){1'b0}}, 1'b1} << K)) : res_in;
            end
        end

        if (j < ROOT_W - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (ce) begin
                    rem_reg[j] <= ge ? rem_in - trial[SUM_W-1:0] : rem_in;
                end
            end
        end
    end

    assign root_o = res_reg[ROOT_W-1];

endmodule

// File: rtl/core/line_pair_closest_approach.sv
// Top level of the closest-approach block: two 3D tracks in, their distance out.
//
// Usage: each request on the s_ channel carries two tracks, a point and a
// direction each, in signed Q15.16. The m_ channel returns one result per
// request, in order: the distance of closest approach in unsigned Q17.16
// (saturating) and a flag that is set when the lines count as parallel.
// Both channels use valid/ready; a request moves when valid and ready are
// high at the same rising edge of aclk.
// Throughput is one request per cycle unless the output stalls. A request
// passes eight front stages for differences, dot products, the split products
// and the determinant, 63 stages of the two quotient dividers (one bit per
// stage), six stages for the closest-point difference and its squares, 35
// stages of the square root (one bit per stage), and the output register.
// The APB port holds the parallel threshold (byte address 0, 40 bits, Q.32);
// write it only while no request is in flight.
// Reset (aresetn low, synchronous) clears every valid bit and loads the
// threshold with its default. When the receiver stalls, the finished result
// stays in the output register and the pipeline keeps moving as long as its
// last stage is empty, so bubbles close up and new requests are still taken;
// once the last stage also holds a result, the whole pipeline and s_ready
// hold until m_ready returns.
module line_pair_closest_approach
    import lpca_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // Sum of three products, floored by 2^16, in Q.16.
    function automatic logic signed [DOT_W-1:0] dot_fix(
        input logic signed [PROD_W-1:0] p0,
        input logic signed [PROD_W-1:0] p1,
        input logic signed [PROD_W-1:0] p2
    );
        logic signed [DOTS_W-1:0] s;
        s = $signed({{(DOTS_W-PROD_W){p0[PROD_W-1]}}, p0})
          + $signed({{(DOTS_W-PROD_W){p1[PROD_W-1]}}, p1})
          + $signed({{(DOTS_W-PROD_W){p2[PROD_W-1]}}, p2});
        return s[DOTS_W-1:DOT_SH];
    endfunction

    // Four partial products of x*y, each operand split into a signed upper
    // part and an unsigned lower word, so no multiplier exceeds 33 by 33 bits.
    function automatic pprod_t mul_split(
        input logic signed [DOT_W-1:0] x,
        input logic signed [DOT_W-1:0] y
    );
        pprod_t p;
        p.hh = $signed(x[DOT_W-1:SPLIT_W]) * $signed(y[DOT_W-1:SPLIT_W]);
        p.hl = $signed(x[DOT_W-1:SPLIT_W]) * $signed({1'b0, y[SPLIT_W-1:0]});
        p.lh = $signed({1'b0, x[SPLIT_W-1:0]}) * $signed(y[DOT_W-1:SPLIT_W]);
        p.ll = x[SPLIT_W-1:0] * y[SPLIT_W-1:0];
        return p;
    endfunction

    // Weighted sum of the partial products: the full signed product.
    function automatic logic signed [MUL_W-1:0] mul_join(input pprod_t p);
        logic signed [MUL_W-1:0] mid;
        mid = $signed({{(MUL_W-PHI_W-SPLIT_W-1){p.hl[PHI_W+SPLIT_W]}}, p.hl})
            + $signed({{(MUL_W-PHI_W-SPLIT_W-1){p.lh[PHI_W+SPLIT_W]}}, p.lh});
        return $signed({p.hh, {(2*SPLIT_W){1'b0}}})
             + (mid <<< SPLIT_W)
             + $signed({{(MUL_W-2*SPLIT_W){1'b0}}, p.ll});
    endfunction

    function automatic logic [WIDE_W-1:0] ext_dot(input logic signed [DOT_W-1:0] x);
        return {{(WIDE_W-DOT_W){x[DOT_W-1]}}, x};
    endfunction

    function automatic logic [WIDE_W-1:0] ext_mul(input logic signed [MUL_W-1:0] x);
        return {{(WIDE_W-MUL_W){x[MUL_W-1]}}, x};
    endfunction

    function automatic logic [WIDE_W-1:0] mag_wide(input logic [WIDE_W-1:0] x);
        return x[WIDE_W-1] ? (~x + 1'b1) : x;
    endfunction

    // Applies zero, saturation and sign to a divider quotient.
    function automatic logic [SCAL_W-1:0] to_scalar(
        input logic [QUO_W-1:0] q,
        input logic             zero,
        input logic             sat,
        input logic             sign
    );
        logic [SCAL_W-1:0] m;
        m = sat ? {1'b0, {QUO_W{1'b1}}} : {1'b0, q};
        if (zero) begin
            m = '0;
        end
        return sign ? (~m + 1'b1) : m;
    endfunction

    // ---------------------------------------------------------------------
    // Configuration register.
    // ---------------------------------------------------------------------
    logic [THR_W-1:0] thr_reg;
    logic             cfg_hit;

    assign cfg_hit = (paddr[PADDR_W-1:ADDR_LSB] == REG_THR);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {{(PDATA_W-THR_W){1'b0}}, thr_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_RESET;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Flow control. The pipeline advances when its last stage is empty or
    // the output register can take that stage's result.
    // ---------------------------------------------------------------------
    logic [PIPE_LEN-1:0] vld_reg;
    logic                out_free;
    logic                ce;
    logic                out_valid_reg;
    out_t                out_reg;

    assign out_free = !out_valid_reg || m_ready;
    assign ce       = !vld_reg[PIPE_LEN-1] || out_free;
    assign s_ready  = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[PIPE_LEN-2:0], s_valid};
        end
    end

    // Stage 0: the accepted request.
    in_t in_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            in_reg <= s_data;
        end
    end

    // Stage 1: directions and the point difference w = P1 - P2.
    vec3_t  u1_reg, v1_reg;
    wvec3_t w1_reg;
    vec3_t  p1, p2, u0, v0;

    assign p1 = {in_reg.first_pos_z, in_reg.first_pos_y, in_reg.first_pos_x};
    assign p2 = {in_reg.second_pos_z, in_reg.second_pos_y, in_reg.second_pos_x};
    assign u0 = {in_reg.first_dir_z, in_reg.first_dir_y, in_reg.first_dir_x};
    assign v0 = {in_reg.second_dir_z, in_reg.second_dir_y, in_reg.second_dir_x};

    always_ff @(posedge aclk) begin
        if (ce) begin
            u1_reg <= u0;
            v1_reg <= v0;
            for (int k = 0; k < 3; k++) begin
                w1_reg[k] <= {p1[k][COORD_W-1], p1[k]} - {p2[k][COORD_W-1], p2[k]};
            end
        end
    end

    // Stage 2: the fifteen component products of the dot products.
    logic signed [PROD_W-1:0] uu2_reg [3];
    logic signed [PROD_W-1:0] uv2_reg [3];
    logic signed [PROD_W-1:0] vv2_reg [3];
    logic signed [PROD_W-1:0] uw2_reg [3];
    logic signed [PROD_W-1:0] vw2_reg [3];
    vec3_t  u2_reg, v2_reg;
    wvec3_t w2_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                uu2_reg[k] <= $signed({u1_reg[k][COORD_W-1], u1_reg[k]})
                            * $signed({u1_reg[k][COORD_W-1], u1_reg[k]});
                uv2_reg[k] <= $signed({u1_reg[k][COORD_W-1], u1_reg[k]})
                            * $signed({v1_reg[k][COORD_W-1], v1_reg[k]});
                vv2_reg[k] <= $signed({v1_reg[k][COORD_W-1], v1_reg[k]})
                            * $signed({v1_reg[k][COORD_W-1], v1_reg[k]});
                uw2_reg[k] <= $signed({u1_reg[k][COORD_W-1], u1_reg[k]})
                            * $signed(w1_reg[k]);
                vw2_reg[k] <= $signed({v1_reg[k][COORD_W-1], v1_reg[k]})
                            * $signed(w1_reg[k]);
            end
            u2_reg <= u1_reg;
            v2_reg <= v1_reg;
            w2_reg <= w1_reg;
        end
    end

    // Stage 3: a = u.u, b = u.v, c = v.v, d = u.w, e = v.w.
    logic signed [DOT_W-1:0] a3_reg, b3_reg, c3_reg, d3_reg, e3_reg;
    vec3_t  u3_reg, v3_reg;
    wvec3_t w3_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            a3_reg <= dot_fix(uu2_reg[0], uu2_reg[1], uu2_reg[2]);
            b3_reg <= dot_fix(uv2_reg[0], uv2_reg[1], uv2_reg[2]);
            c3_reg <= dot_fix(vv2_reg[0], vv2_reg[1], vv2_reg[2]);
            d3_reg <= dot_fix(uw2_reg[0], uw2_reg[1], uw2_reg[2]);
            e3_reg <= dot_fix(vw2_reg[0], vw2_reg[1], vw2_reg[2]);
            u3_reg <= u2_reg;
            v3_reg <= v2_reg;
            w3_reg <= w2_reg;
        end
    end

    // Stage 4a: partial products behind D and the two numerators.
    pprod_t                  ac4a_reg, bb4a_reg, be4a_reg, cd4a_reg, ae4a_reg, bd4a_reg;
    logic signed [DOT_W-1:0] b4a_reg, c4a_reg, d4a_reg, e4a_reg;
    vec3_t  u4a_reg, v4a_reg;
    wvec3_t w4a_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ac4a_reg <= mul_split(a3_reg, c3_reg);
            bb4a_reg <= mul_split(b3_reg, b3_reg);
            be4a_reg <= mul_split(b3_reg, e3_reg);
            cd4a_reg <= mul_split(c3_reg, d3_reg);
            ae4a_reg <= mul_split(a3_reg, e3_reg);
            bd4a_reg <= mul_split(b3_reg, d3_reg);
            b4a_reg  <= b3_reg;
            c4a_reg  <= c3_reg;
            d4a_reg  <= d3_reg;
            e4a_reg  <= e3_reg;
            u4a_reg  <= u3_reg;
            v4a_reg  <= v3_reg;
            w4a_reg  <= w3_reg;
        end
    end

    // Stage 4b: the full products, assembled from their parts.
    logic signed [MUL_W-1:0] ac4_reg, bb4_reg, be4_reg, cd4_reg, ae4_reg, bd4_reg;
    logic signed [DOT_W-1:0] b4_reg, c4_reg, d4_reg, e4_reg;
    vec3_t  u4_reg, v4_reg;
    wvec3_t w4_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            ac4_reg <= mul_join(ac4a_reg);
            bb4_reg <= mul_join(bb4a_reg);
            be4_reg <= mul_join(be4a_reg);
            cd4_reg <= mul_join(cd4a_reg);
            ae4_reg <= mul_join(ae4a_reg);
            bd4_reg <= mul_join(bd4a_reg);
            b4_reg  <= b4a_reg;
            c4_reg  <= c4a_reg;
            d4_reg  <= d4a_reg;
            e4_reg  <= e4a_reg;
            u4_reg  <= u4a_reg;
            v4_reg  <= v4a_reg;
            w4_reg  <= w4a_reg;
        end
    end

    // Stage 5: D = ac - b^2 and the parallel decision. A negative D, which
    // only arises from the flooring of a, b and c, counts as parallel.
    logic [WIDE_W-1:0] det_next, det5_reg, ns5_reg, nt5_reg;
    logic              par_next, par5_reg;
    logic signed [DOT_W-1:0] b5_reg, c5_reg, d5_reg, e5_reg;
    vec3_t  u5_reg, v5_reg;
    wvec3_t w5_reg;

    assign det_next = ext_mul(ac4_reg) - ext_mul(bb4_reg);
    assign par_next = det_next[WIDE_W-1]
                   || (det_next < {{(WIDE_W-THR_W){1'b0}}, thr_reg});

    always_ff @(posedge aclk) begin
        if (ce) begin
            det5_reg <= det_next;
            par5_reg <= par_next;
            ns5_reg  <= ext_mul(be4_reg) - ext_mul(cd4_reg);
            nt5_reg  <= ext_mul(ae4_reg) - ext_mul(bd4_reg);
            b5_reg   <= b4_reg;
            c5_reg   <= c4_reg;
            d5_reg   <= d4_reg;
            e5_reg   <= e4_reg;
            u5_reg   <= u4_reg;
            v5_reg   <= v4_reg;
            w5_reg   <= w4_reg;
        end
    end

    // Stage 6: divider operands. In the parallel case only t is divided,
    // by the larger of b and c; otherwise both s and t are divided by D.
    logic              bgt;
    logic [WIDE_W-1:0] numt_sel, dent_sel;
    logic [WIDE_W-1:0] nums6_reg, numt6_reg, dens6_reg, dent6_reg;
    logic              sign_s6_reg, sign_t6_reg, zero_s6_reg, zero_t6_reg, par6_reg;
    vec3_t  u6_reg, v6_reg;
    wvec3_t w6_reg;

    assign bgt      = (b5_reg > c5_reg);
    assign numt_sel = par5_reg ? (bgt ? ext_dot(d5_reg) : ext_dot(e5_reg)) : nt5_reg;
    assign dent_sel = par5_reg ? (bgt ? ext_dot(b5_reg) : ext_dot(c5_reg)) : det5_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            nums6_reg   <= mag_wide(ns5_reg);
            dens6_reg   <= det5_reg;
            numt6_reg   <= mag_wide(numt_sel);
            dent6_reg   <= mag_wide(dent_sel);
            sign_s6_reg <= ns5_reg[WIDE_W-1];
            sign_t6_reg <= numt_sel[WIDE_W-1] ^ dent_sel[WIDE_W-1];
            zero_s6_reg <= par5_reg || (det5_reg == '0);
            zero_t6_reg <= (dent_sel == '0);
            par6_reg    <= par5_reg;
            u6_reg      <= u5_reg;
            v6_reg      <= v5_reg;
            w6_reg      <= w5_reg;
        end
    end

    // Dividers. A quotient of 2^63 or more saturates; that is known up
    // front from num >= den * 2^31 and travels with the side data.
    logic [QUO_W-1:0] quo_s, quo_t;
    div_side_t        dside_next;
    div_side_t        dside_reg [DIV_LAT];

    lpca_div u_div_s (
        .aclk  (aclk),
        .ce    (ce),
        .num_i (nums6_reg),
        .den_i (dens6_reg),
        .quo_o (quo_s)
    );

    lpca_div u_div_t (
        .aclk  (aclk),
        .ce    (ce),
        .num_i (numt6_reg),
        .den_i (dent6_reg),
        .quo_o (quo_t)
    );

    always_comb begin
        dside_next.u      = u6_reg;
        dside_next.v      = v6_reg;
        dside_next.w      = w6_reg;
        dside_next.par    = par6_reg;
        dside_next.sign_s = sign_s6_reg;
        dside_next.sign_t = sign_t6_reg;
        dside_next.zero_s = zero_s6_reg;
        dside_next.zero_t = zero_t6_reg;
        dside_next.sat_s  = ({{SAT_SH{1'b0}}, nums6_reg} >= {dens6_reg, {SAT_SH{1'b0}}});
        dside_next.sat_t  = ({{SAT_SH{1'b0}}, numt6_reg} >= {dent6_reg, {SAT_SH{1'b0}}});
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            dside_reg[0] <= dside_next;
            for (int i = 1; i < DIV_LAT; i++) begin
                dside_reg[i] <= dside_reg[i-1];
            end
        end
    end

    // Stage 7: the line parameters sc and tc in Q31.32.
    div_side_t         dlast;
    logic [SCAL_W-1:0] sc7_reg, tc7_reg;
    vec3_t             u7_reg, v7_reg;
    wvec3_t            w7_reg;
    logic              par7_reg;

    assign dlast = dside_reg[DIV_LAT-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            sc7_reg  <= to_scalar(quo_s, dlast.zero_s, dlast.sat_s, dlast.sign_s);
            tc7_reg  <= to_scalar(quo_t, dlast.zero_t, dlast.sat_t, dlast.sign_t);
            u7_reg   <= dlast.u;
            v7_reg   <= dlast.v;
            w7_reg   <= dlast.w;
            par7_reg <= dlast.par;
        end
    end

    // Stage 8: sc*u and tc*v, each split into a signed upper half and an
    // unsigned lower half product.
    logic signed [PPH_W-1:0] suh8_reg [3];
    logic signed [PPL_W-1:0] sul8_reg [3];
    logic signed [PPH_W-1:0] tvh8_reg [3];
    logic signed [PPL_W-1:0] tvl8_reg [3];
    wvec3_t w8_reg;
    logic   par8_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                suh8_reg[k] <= $signed(sc7_reg[SCAL_W-1:HALF_W]) * $signed(u7_reg[k]);
                sul8_reg[k] <= $signed({1'b0, sc7_reg[HALF_W-1:0]}) * $signed(u7_reg[k]);
                tvh8_reg[k] <= $signed(tc7_reg[SCAL_W-1:HALF_W]) * $signed(v7_reg[k]);
                tvl8_reg[k] <= $signed({1'b0, tc7_reg[HALF_W-1:0]}) * $signed(v7_reg[k]);
            end
            w8_reg   <= w7_reg;
            par8_reg <= par7_reg;
        end
    end

    // Stage 9: closest-point difference w + sc*u - tc*v, exact in Q.48.
    logic [COMP_W-1:0] comp9_reg [3];
    logic              par9_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                comp9_reg[k] <=
                      {{(COMP_W-DIFF_W-HALF_W){w8_reg[k][DIFF_W-1]}}, w8_reg[k], {HALF_W{1'b0}}}
                    + {{(COMP_W-PPH_W-HALF_W){suh8_reg[k][PPH_W-1]}}, suh8_reg[k],
                       {HALF_W{1'b0}}}
                    + {{(COMP_W-PPL_W){sul8_reg[k][PPL_W-1]}}, sul8_reg[k]}
                    - {{(COMP_W-PPH_W-HALF_W){tvh8_reg[k][PPH_W-1]}}, tvh8_reg[k],
                       {HALF_W{1'b0}}}
                    - {{(COMP_W-PPL_W){tvl8_reg[k][PPL_W-1]}}, tvl8_reg[k]};
            end
            par9_reg <= par8_reg;
        end
    end

    // Stage 10: component magnitudes truncated to Q.16, with overflow check.
    logic [COMP_W-1:0] cmag [3];
    logic [DIST_W-1:0] m10_reg [3];
    logic              big10_reg, par10_reg;
    logic              big_next;

    always_comb begin
        big_next = 1'b0;
        for (int k = 0; k < 3; k++) begin
            cmag[k]  = comp9_reg[k][COMP_W-1] ? (~comp9_reg[k] + 1'b1) : comp9_reg[k];
            big_next = big_next || (|cmag[k][COMP_W-1:HALF_W+DIST_W]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                m10_reg[k] <= cmag[k][HALF_W+DIST_W-1:HALF_W];
            end
            big10_reg <= big_next;
            par10_reg <= par9_reg;
        end
    end

    // Stage 11: squares.
    logic [SQ_W-1:0] sq11_reg [3];
    logic            big11_reg, par11_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                sq11_reg[k] <= m10_reg[k] * m10_reg[k];
            end
            big11_reg <= big10_reg;
            par11_reg <= par10_reg;
        end
    end

    // Stage 12: sum of squares.
    logic [SUM_W-1:0] sum12_reg;
    logic             big12_reg, par12_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            sum12_reg <= {{(SUM_W-SQ_W){1'b0}}, sq11_reg[0]}
                       + {{(SUM_W-SQ_W){1'b0}}, sq11_reg[1]}
                       + {{(SUM_W-SQ_W){1'b0}}, sq11_reg[2]};
            big12_reg <= big11_reg;
            par12_reg <= par11_reg;
        end
    end

    // Square root, with the overflow and parallel flags alongside.
    logic [ROOT_W-1:0] root;
    logic [1:0]        sside_reg [SQRT_LAT];

    lpca_sqrt u_sqrt (
        .aclk   (aclk),
        .ce     (ce),
        .sum_i  (sum12_reg),
        .root_o (root)
    );

    always_ff @(posedge aclk) begin
        if (ce) begin
            sside_reg[0] <= {big12_reg, par12_reg};
            for (int i = 1; i < SQRT_LAT; i++) begin
                sside_reg[i] <= sside_reg[i-1];
            end
        end
    end

    // Output register: the distance saturates at its full-scale value.
    out_t out_next;

    always_comb begin
        out_next.parallel_flag = sside_reg[SQRT_LAT-1][0];
        if (sside_reg[SQRT_LAT-1][1] || (|root[ROOT_W-1:DIST_W])) begin
            out_next.closest_distance = DIST_MAX;
        end else begin
            out_next.closest_distance = root[DIST_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= vld_reg[PIPE_LEN-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// File: rtl/core/lpca_checker.sv
// Port-level checker for the closest-approach block, bound to its top level.
`include "line_pair_closest_approach_assert.svh"

module lpca_checker
    import lpca_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input out_t               m_data,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    // A result that is not taken stays on the port unchanged.
    `LPCA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // Reset empties the output register.
    `LPCA_ASSERT_NEXT_NORST(a_reset_empty, aclk, !aresetn, !m_valid, "result valid after reset")

    // Requests are refused only while a result waits at a stalled output.
    `LPCA_ASSERT_NOW(a_ready_cause, aclk, aresetn, !s_ready, m_valid && !m_ready, "input blocked without output stall")

    // A threshold write reads back on the following cycle.
    `LPCA_ASSERT_NEXT(a_thr_readback, aclk, aresetn, psel && penable && pwrite && pready && (paddr[PADDR_W-1:ADDR_LSB] == REG_THR), (paddr[PADDR_W-1:ADDR_LSB] != REG_THR) || (prdata[THR_W-1:0] == $past(pwdata[THR_W-1:0])), "threshold readback mismatch")

endmodule

bind line_pair_closest_approach lpca_checker u_lpca_checker (.*);

// File: tb/lpca_checker.sv
// Checker for the closest-approach block: predicts each result and compares it.
`timescale 1ns / 1ps

module lpca_tb_checker
    import lpca_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  in_t                s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  out_t               m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 mismatches,
    output int                 outstanding
);

    typedef logic signed [255:0] big_t;

    logic [THR_W-1:0] thr_shadow;
    out_t             expected_distances[$];

    function automatic big_t dot3(big_t x0, big_t x1, big_t x2, big_t y0, big_t y1, big_t y2);
        return (x0 * y0 + x1 * y1 + x2 * y2) >>> DOT_SH;
    endfunction

    // Q.32 quotient: magnitude truncated, saturated at 2^63-1, sign applied last.
    function automatic big_t qdiv(big_t num, big_t den);
        logic [255:0] nm;
        logic [255:0] dm;
        logic [255:0] q;
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        q = (nm << QFRAC_W) / dm;
        if (q > 256'h7FFF_FFFF_FFFF_FFFF) q = 256'h7FFF_FFFF_FFFF_FFFF;
        return ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
    endfunction

    function automatic out_t predict_distance(in_t r, logic [THR_W-1:0] thr);
        big_t u[3], v[3], w[3];
        big_t a, b, c, d, e, det, sc, tc, comp;
        logic [255:0] mag;
        logic [127:0] sum, root, cand;
        logic big, par;
        out_t o;
        u[0] = $signed(r.first_dir_x);  u[1] = $signed(r.first_dir_y);
        u[2] = $signed(r.first_dir_z);
        v[0] = $signed(r.second_dir_x); v[1] = $signed(r.second_dir_y);
        v[2] = $signed(r.second_dir_z);
        w[0] = big_t'($signed(r.first_pos_x)) - big_t'($signed(r.second_pos_x));
        w[1] = big_t'($signed(r.first_pos_y)) - big_t'($signed(r.second_pos_y));
        w[2] = big_t'($signed(r.first_pos_z)) - big_t'($signed(r.second_pos_z));
        a = dot3(u[0], u[1], u[2], u[0], u[1], u[2]);
        b = dot3(u[0], u[1], u[2], v[0], v[1], v[2]);
        c = dot3(v[0], v[1], v[2], v[0], v[1], v[2]);
        d = dot3(u[0], u[1], u[2], w[0], w[1], w[2]);
        e = dot3(v[0], v[1], v[2], w[0], w[1], w[2]);
        det = a * c - b * b;
        // A negative determinant comes only from rounding and counts as parallel.
        par = (det < 0) || (det < $signed({216'd0, thr}));
        sc = 0;
        tc = 0;
        if (par) begin
            if (b > c && b != 0) tc = qdiv(d, b);
            else if (b <= c && c != 0) tc = qdiv(e, c);
        end else if (det != 0) begin
            sc = qdiv(b * e - c * d, det);
            tc = qdiv(a * e - b * d, det);
        end
        big = 1'b0;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            comp = (w[k] <<< 32) + sc * u[k] - tc * v[k];
            mag = (comp < 0) ? -comp : comp;
            mag = mag >> 32;
            if (mag > 256'(DIST_MAX)) big = 1'b1;
            else sum += mag[127:0] * mag[127:0];
        end
        root = '0;
        if (big) begin
            root = 128'(DIST_MAX);
        end else begin
            for (int k = ROOT_W - 1; k >= 0; k--) begin
                cand = root | (128'd1 << k);
                if (cand * cand <= sum) root = cand;
            end
            if (root > 128'(DIST_MAX)) root = 128'(DIST_MAX);
        end
        o.closest_distance = root[DIST_W-1:0];
        o.parallel_flag = par;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            thr_shadow <= THR_RESET;
            expected_distances.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr[PADDR_W-1:ADDR_LSB] == REG_THR)
                thr_shadow <= pwdata[THR_W-1:0];
            if (s_valid && s_ready)
                expected_distances.push_back(predict_distance(s_data, thr_shadow));
            if (m_valid && m_ready) begin
                if (expected_distances.size() == 0) begin
                    report_mismatch("unexpected result", 64'(m_data), 64'd0);
                end else begin
                    want = expected_distances.pop_front();
                    if (m_data.closest_distance !== want.closest_distance)
                        report_mismatch("closest_distance", 64'(m_data.closest_distance),
                                        64'(want.closest_distance));
                    if (m_data.parallel_flag !== want.parallel_flag)
                        report_mismatch("parallel_flag", 64'(m_data.parallel_flag),
                                        64'(want.parallel_flag));
                end
            end
        end
        outstanding = expected_distances.size();
    end

endmodule

// File: tb/tb.sv
// Top of the closest-approach testbench: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb;
    import lpca_pkg::*;

    // Settle for longer than the depth of the pipeline.
    localparam int SETTLE = 130;
    localparam int CYCLE_LIMIT = 400000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    in_t                s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    out_t               m_data;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 mismatches;
    int                 outstanding;
    int                 cycles = 0;
    // When set, neither side idles, so back-to-back streaming is exercised too.
    logic               no_idle = 1'b0;

    always #5 aclk = ~aclk;

    line_pair_closest_approach i_dut (.*);

    lpca_tb_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata, .mismatches, .outstanding
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // The receiver stalls the result channel on its own schedule.
    always @(posedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            stall = gap_len();
            if (stall == 0) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                repeat (stall - 1) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // One request: optional gap with valid low, then hold valid until it is taken.
    // Valid is not lowered between back-to-back requests.
    task automatic send_request(in_t req);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Registers are only touched once every request has drained out.
    task automatic write_threshold(logic [THR_W-1:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_THR) << ADDR_LSB;
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(int scale);
        logic [31:0] x;
        x = $urandom();
        if (scale == 0) return x;
        return 32'($signed(x) >>> scale);
    endfunction

    // Random track pairs: fully random words, moderate values, and
    // near-parallel pairs where the second direction is a scaled first one.
    function automatic in_t random_request();
        in_t r;
        int mode, sh, scale;
        mode = $urandom_range(0, 9);
        scale = (mode < 3) ? 0 : $urandom_range(4, 16);
        r.first_pos_x  = rand_coord(scale);
        r.first_pos_y  = rand_coord(scale);
        r.first_pos_z  = rand_coord(scale);
        r.first_dir_x  = rand_coord(scale);
        r.first_dir_y  = rand_coord(scale);
        r.first_dir_z  = rand_coord(scale);
        r.second_pos_x = rand_coord(scale);
        r.second_pos_y = rand_coord(scale);
        r.second_pos_z = rand_coord(scale);
        r.second_dir_x = rand_coord(scale);
        r.second_dir_y = rand_coord(scale);
        r.second_dir_z = rand_coord(scale);
        if (mode >= 7) begin
            sh = $urandom_range(0, 3);
            r.second_dir_x = (r.first_dir_x >>> sh) + $signed(32'($urandom_range(0, 3)) - 1);
            r.second_dir_y = (r.first_dir_y >>> sh) + $signed(32'($urandom_range(0, 3)) - 1);
            r.second_dir_z = (r.first_dir_z >>> sh);
            if (mode == 9) begin
                r.second_dir_x = -r.second_dir_x;
                r.second_dir_y = -r.second_dir_y;
                r.second_dir_z = -r.second_dir_z;
            end
        end
        return r;
    endfunction

    function automatic in_t make_request(logic [31:0] p1x, logic [31:0] p1y, logic [31:0] p1z,
                                         logic [31:0] u_x, logic [31:0] u_y, logic [31:0] u_z,
                                         logic [31:0] p2x, logic [31:0] p2y, logic [31:0] p2z,
                                         logic [31:0] v_x, logic [31:0] v_y, logic [31:0] v_z);
        return {p1x, p1y, p1z, u_x, u_y, u_z, p2x, p2y, p2z, v_x, v_y, v_z};
    endfunction

    // Directed cases: all zero, zero directions (zero divisor), identical and
    // opposite directions, the larger-of-b-and-c choice, crossing and skew
    // lines, and the field extremes that drive the distance into saturation.
    task automatic directed_requests();
        localparam logic [31:0] ONE = 32'h0001_0000;
        localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
        localparam logic [31:0] MINV = 32'h8000_0000;
        send_request('0);
        send_request(make_request(ONE, 0, 0, 0, 0, 0, 0, ONE, 0, 0, 0, 0));
        send_request(make_request(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, 0, 0));
        send_request(make_request(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, 0, 0));
        send_request(make_request(0, 0, 0, ONE << 4, 0, 0, 0, 0, ONE, ONE, 0, 0));
        send_request(make_request(0, 0, 0, ONE, 0, 0, 0, 0, ONE, ONE << 4, 0, 0));
        send_request(make_request(0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0, ONE, 0));
        send_request(make_request(0, 0, 0, ONE, 0, 0, 0, 0, 0, 0, ONE, 0));
        send_request(make_request(ONE, 2 * ONE, 3 * ONE, ONE, ONE, 0,
                                  -ONE, 0, 5 * ONE, 0, ONE, ONE));
        send_request(make_request(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV,
                                  MINV, MINV, MINV, MINV, MINV, MINV));
        send_request(make_request(MINV, MINV, MINV, MINV, MINV, MINV,
                                  MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
        send_request(make_request(MAXV, MINV, MAXV, 0, 0, 0, MINV, MAXV, MINV, 0, 0, 0));
        send_request(make_request(MAXV, 0, 0, MAXV, 0, 0, MINV, 0, 0, 0, MAXV, 0));
        send_request(make_request(0, 0, 0, 1, 0, 0, 0, 0, 1, 0, 1, 0));
        send_request(make_request(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, ONE, 0, 32'hFFFF_FFFF, 1, 0));
        send_request({12{32'hFFFF_FFFF}});
    endtask

    initial begin
        logic [THR_W-1:0] thresholds[5];
        thresholds[0] = THR_RESET;
        thresholds[1] = '0;
        thresholds[2] = {THR_W{1'b1}};
        thresholds[3] = THR_W'(64'd1 << 32);
        thresholds[4] = THR_W'({$urandom(), $urandom()});
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Each phase runs under one threshold: the default, zero, the maximum,
        // one in Q.32, and a random value.
        for (int ph = 0; ph < 5; ph++) begin
            write_threshold(thresholds[ph]);
            no_idle = (ph == 3);
            directed_requests();
            repeat (64) send_request(random_request());
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
